// ===== design/nbf_pkg.sv =====
// Shared widths and defaults for the nearest bounded fraction unit.
package nbf_pkg;

    localparam int FIELD_W     = 15;
    localparam int TDATA_W     = 32;
    localparam int MAX_DEN_DEF = 32767;
    localparam int DEN_W_DEF   = $clog2(MAX_DEN_DEF + 1);

endpackage

// ===== design/nbf_xmul.sv =====
// Shared cross-multiply unit: forms a*b and c*d, their difference and their order.
module nbf_xmul #(
    parameter int AW = nbf_pkg::FIELD_W + nbf_pkg::DEN_W_DEF,
    parameter int BW = nbf_pkg::DEN_W_DEF
) (
    input  logic [AW-1:0]    a,
    input  logic [BW-1:0]    b,
    input  logic [BW-1:0]    c,
    input  logic [AW-1:0]    d,
    output logic             lt,
    output logic [AW+BW-1:0] diff
);

    logic [AW+BW-1:0] prod_ab;
    logic [AW+BW-1:0] prod_cd;

    assign prod_ab = (AW+BW)'(a) * (AW+BW)'(b);
    assign prod_cd = (AW+BW)'(c) * (AW+BW)'(d);

    // diff is only taken where the first product is known to be the larger
    assign lt   = prod_ab < prod_cd;
    assign diff = prod_ab - prod_cd;

endmodule

// ===== design/nearest_bounded_fraction_unit.sv =====
// Top level of the nearest bounded fraction unit: sequencer, scan registers and output word.
//
// Finds the nearest other fraction, denominator at most MAX_DEN, to a target
// n/d in (0,1), in lowest terms; zero gives 0/1, one and above give 1/1.
// Input channel s_axis: one word holds numerator (bits 14:0) and denominator
// (bits 29:15); a zero denominator counts as one. Output channel m_axis: one
// word per input word, numerator in bits 14:0, denominator in bits 29:15.
//
// A target strictly between 0 and 1 gives a valid output word only after the
// full denominator scan and the BELOW, ABOVE, PICK and DONE steps. The cost
// is set by the denominator scan: every denominator passes twice through the
// single cross-multiply unit, once for the bound below and once for the bound
// above. Targets of zero, or of one and above, skip the scan and go straight
// to the DONE step. One word is in work at a time; s_axis_tready is high only
// while the sequencer is idle.
// The result sits in an output register, so a new word is taken while an
// earlier result still waits on a stalled receiver. A finished result that
// finds the output register still full holds until m_axis_tready frees it.
// Reset (rst_n low, asynchronous) drops any word in work and any pending
// output; no state carries over from one word to the next.
module nearest_bounded_fraction_unit #(
    parameter int MAX_DEN = nbf_pkg::MAX_DEN_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    // fields from bit 0: numerator_in[14:0], denominator_in[29:15], zero pad
    input  logic [nbf_pkg::TDATA_W-1:0] s_axis_tdata,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // fields from bit 0: near_numerator[14:0], near_denominator[29:15], zero pad
    output logic [nbf_pkg::TDATA_W-1:0] m_axis_tdata
);

    localparam int FW = nbf_pkg::FIELD_W;
    localparam int TW = nbf_pkg::TDATA_W;
    localparam int KW = $clog2(MAX_DEN + 1);   // denominator scan width
    localparam int AW = FW + KW;               // scaled distance width
    localparam logic [KW-1:0] K_LAST = KW'(MAX_DEN);

    // sequencer codes
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_LO    = 3'd1;
    localparam logic [2:0] S_HI    = 3'd2;
    localparam logic [2:0] S_BELOW = 3'd3;
    localparam logic [2:0] S_ABOVE = 3'd4;
    localparam logic [2:0] S_PICK  = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    logic [2:0]    state_reg, state_next;
    logic          out_valid_reg, out_valid_next;
    logic [FW-1:0] out_n_reg, out_n_next;
    logic [FW-1:0] out_d_reg, out_d_next;

    logic [FW-1:0] tn_reg, tn_next;
    logic [FW-1:0] td_reg, td_next;
    logic [KW-1:0] k_reg, k_next;
    logic [KW-1:0] q_reg, q_next;       // floor(k*tn/td)
    logic [FW-1:0] r_reg, r_next;       // k*tn mod td
    logic [KW-1:0] lo_n_reg, lo_n_next;
    logic [KW-1:0] lo_d_reg, lo_d_next;
    logic [KW-1:0] hi_n_reg, hi_n_next;
    logic [KW-1:0] hi_d_reg, hi_d_next;
    logic [AW-1:0] below_reg, below_next;
    logic [AW-1:0] above_reg, above_next;
    logic [FW-1:0] res_n_reg, res_n_next;
    logic [FW-1:0] res_d_reg, res_d_next;

    logic [FW-1:0] in_n;
    logic [FW-1:0] in_d;
    logic [FW-1:0] in_d_eff;
    logic          in_accept;

    logic          exact;
    logic [KW-1:0] c_up;        // smallest c with c/k at or above the target
    logic [KW-1:0] lc;
    logic [KW-1:0] uc;
    logic [FW:0]   r_sum;
    logic          r_wrap;

    logic [AW-1:0]    mul_a;
    logic [KW-1:0]    mul_b;
    logic [KW-1:0]    mul_c;
    logic [AW-1:0]    mul_d;
    logic             mul_lt;
    logic [AW+KW-1:0] mul_diff;

    assign in_n      = s_axis_tdata[FW-1:0];
    assign in_d      = s_axis_tdata[2*FW-1:FW];
    assign in_d_eff  = (in_d == '0) ? FW'(1) : in_d;
    assign in_accept = s_axis_tvalid && s_axis_tready;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(TW - 2*FW){1'b0}}, out_d_reg, out_n_reg};

    // candidates for the current denominator; inside the scan 0 < tn < td,
    // so 1 <= c_up <= k and neither candidate leaves the scan width
    assign exact = (r_reg == '0);
    assign c_up  = q_reg + KW'(!exact);
    assign lc    = c_up - KW'(1);
    assign uc    = exact ? c_up + KW'(1) : c_up;

    // advance k*tn by one more tn, one wrap at most since r, tn < td
    assign r_sum  = {1'b0, r_reg} + {1'b0, tn_reg};
    assign r_wrap = r_sum >= {1'b0, td_reg};

    // operand selection for the shared unit
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        mul_c = '0;
        mul_d = '0;
        unique case (state_reg)
            S_LO:
            begin
                // lo_n*k < lc*lo_d : candidate lies above the current lower bound
                mul_a = AW'(lo_n_reg);
                mul_b = k_reg;
                mul_c = lc;
                mul_d = AW'(lo_d_reg);
            end
            S_HI:
            begin
                // uc*hi_d < hi_n*k : candidate lies below the current upper bound
                mul_a = AW'(uc);
                mul_b = hi_d_reg;
                mul_c = hi_n_reg;
                mul_d = AW'(k_reg);
            end
            S_BELOW:
            begin
                mul_a = AW'(tn_reg);
                mul_b = lo_d_reg;
                mul_c = lo_n_reg;
                mul_d = AW'(td_reg);
            end
            S_ABOVE:
            begin
                mul_a = AW'(td_reg);
                mul_b = hi_n_reg;
                mul_c = hi_d_reg;
                mul_d = AW'(tn_reg);
            end
            S_PICK:
            begin
                mul_a = below_reg;
                mul_b = hi_d_reg;
                mul_c = lo_d_reg;
                mul_d = above_reg;
            end
            default:
            begin
                mul_a = '0;
            end
        endcase
    end

    nbf_xmul #(
        .AW (AW),
        .BW (KW)
    ) u_xmul (
        .a    (mul_a),
        .b    (mul_b),
        .c    (mul_c),
        .d    (mul_d),
        .lt   (mul_lt),
        .diff (mul_diff)
    );

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        out_n_next     = out_n_reg;
        out_d_next     = out_d_reg;
        tn_next        = tn_reg;
        td_next        = td_reg;
        k_next         = k_reg;
        q_next         = q_reg;
        r_next         = r_reg;
        lo_n_next      = lo_n_reg;
        lo_d_next      = lo_d_reg;
        hi_n_next      = hi_n_reg;
        hi_d_next      = hi_d_reg;
        below_next     = below_reg;
        above_next     = above_reg;
        res_n_next     = res_n_reg;
        res_d_next     = res_d_reg;

        // drop the output word once taken; a load below overrides this
        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    tn_next   = in_n;
                    td_next   = in_d_eff;
                    k_next    = KW'(1);
                    q_next    = '0;
                    r_next    = in_n;
                    lo_n_next = '0;
                    lo_d_next = KW'(1);
                    hi_n_next = KW'(1);
                    hi_d_next = KW'(1);
                    priority if (in_n == '0)
                    begin
                        // zero target: the bound below stays 0/1 and wins
                        res_n_next = '0;
                        res_d_next = FW'(1);
                        state_next = S_DONE;
                    end
                    else if (in_n >= in_d_eff)
                    begin
                        // target at or above one: the bound above stays 1/1 and wins
                        res_n_next = FW'(1);
                        res_d_next = FW'(1);
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_LO;
                    end
                end
            end
            S_LO:
            begin
                if (mul_lt)
                begin
                    lo_n_next = lc;
                    lo_d_next = k_reg;
                end
                state_next = S_HI;
            end
            S_HI:
            begin
                if (mul_lt)
                begin
                    hi_n_next = uc;
                    hi_d_next = k_reg;
                end
                if (k_reg == K_LAST)
                begin
                    state_next = S_BELOW;
                end
                else
                begin
                    k_next = k_reg + KW'(1);
                    if (r_wrap)
                    begin
                        r_next = FW'(r_sum - {1'b0, td_reg});
                        q_next = q_reg + KW'(1);
                    end
                    else
                    begin
                        r_next = FW'(r_sum);
                    end
                    state_next = S_LO;
                end
            end
            S_BELOW:
            begin
                below_next = AW'(mul_diff);
                state_next = S_ABOVE;
            end
            S_ABOVE:
            begin
                above_next = AW'(mul_diff);
                state_next = S_PICK;
            end
            S_PICK:
            begin
                // bounds only move on a strict gain, so each is already in
                // lowest terms; the upper one wins a tie
                if (mul_lt)
                begin
                    res_n_next = FW'(lo_n_reg);
                    res_d_next = FW'(lo_d_reg);
                end
                else
                begin
                    res_n_next = FW'(hi_n_reg);
                    res_d_next = FW'(hi_d_reg);
                end
                state_next = S_DONE;
            end
            S_DONE:
            begin
                // hold until the output register is free
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_n_next     = res_n_reg;
                    out_d_next     = res_d_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_n_reg <= out_n_next;
        out_d_reg <= out_d_next;
        tn_reg    <= tn_next;
        td_reg    <= td_next;
        k_reg     <= k_next;
        q_reg     <= q_next;
        r_reg     <= r_next;
        lo_n_reg  <= lo_n_next;
        lo_d_reg  <= lo_d_next;
        hi_n_reg  <= hi_n_next;
        hi_d_reg  <= hi_d_next;
        below_reg <= below_next;
        above_reg <= above_next;
        res_n_reg <= res_n_next;
        res_d_reg <= res_d_next;
    end

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the nearest bounded fraction unit.
`timescale 1ns / 100ps

module tb_top;

    // Run the unit at its full denominator bound: every target strictly
    // between 0 and 1 costs one complete scan of every denominator.
    localparam int  BOUND          = nbf_pkg::MAX_DEN_DEF;
    localparam int  FW             = nbf_pkg::FIELD_W;
    localparam int  TW             = nbf_pkg::TDATA_W;
    localparam int  SCAN_CYCLES    = 2 * BOUND + 4;
    localparam int  IDLE_MAX       = 18;
    localparam int  DIRECTED_ITEMS = 20;
    localparam int  RANDOM_ITEMS   = 62;
    localparam int  B2B_ITEMS      = 12;
    localparam int  FILL_ITEMS     = 6;
    localparam int  ITEM_TOTAL     = DIRECTED_ITEMS + RANDOM_ITEMS + B2B_ITEMS + FILL_ITEMS;
    localparam int  FILL_HOLD      = 3 * SCAN_CYCLES + 200;
    localparam longint CYCLE_LIMIT =
        4 * (longint'(ITEM_TOTAL) * (SCAN_CYCLES + 2 * IDLE_MAX + 8) + FILL_HOLD);

    // One fraction as it travels in a word: numerator in the low 15 bits.
    typedef struct packed {
        logic [FW-1:0] den;
        logic [FW-1:0] num;
    } fraction_t;

    logic          clk = 1'b0;
    logic          rst_n = 1'b0;
    logic          s_axis_tvalid = 1'b0;
    logic          s_axis_tready;
    logic [TW-1:0] s_axis_tdata = '0;
    logic          m_axis_tvalid;
    logic          m_axis_tready = 1'b0;
    logic [TW-1:0] m_axis_tdata;

    fraction_t expected_nearest[$];
    int        error_count = 0;
    longint    cycle_count = 0;
    int        sender_idle_max = IDLE_MAX;
    int        receiver_stall_max = IDLE_MAX;
    int        hold_request = 0;

    nearest_bounded_fraction_unit #(
        .MAX_DEN(BOUND)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Guard against a hung block: end the run well past the slowest correct one.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // Nearest fraction, denominator up to BOUND, other than a target inside (0,1).
    // Scan every denominator, keep the tightest bound below and above, pick
    // the nearer one (upper on a tie), then reduce by Euclid's gcd.
    function automatic fraction_t nearest_fraction(input fraction_t target);
        longint    tn;
        longint    td;
        longint    lo_n;
        longint    lo_d;
        longint    hi_n;
        longint    hi_d;
        longint    c;
        longint    lc;
        longint    uc;
        longint    below;
        longint    above;
        longint    an;
        longint    ad;
        longint    a;
        longint    b;
        longint    t;
        fraction_t answer;
        tn = target.num;
        td = (target.den == 0) ? 1 : target.den;
        lo_n = 0;
        lo_d = 1;
        hi_n = 1;
        hi_d = 1;
        for (longint k = 1; k <= BOUND; k++)
        begin
            // smallest c with c/k at or above the target
            c  = (k * tn + td - 1) / td;
            lc = c - 1;
            uc = (c * td == k * tn) ? c + 1 : c;
            if (lo_n * k < lc * lo_d)
            begin
                lo_n = lc;
                lo_d = k;
            end
            if (uc * hi_d < hi_n * k)
            begin
                hi_n = uc;
                hi_d = k;
            end
        end
        below = tn * lo_d - lo_n * td;
        above = hi_n * td - tn * hi_d;
        if (below * hi_d - lo_d * above < 0)
        begin
            an = lo_n;
            ad = lo_d;
        end
        else
        begin
            an = hi_n;
            ad = hi_d;
        end
        a = an;
        b = ad;
        while (a != 0)
        begin
            t = a;
            a = b % a;
            b = t;
        end
        if (b == 0)
            b = 1;
        answer.num = FW'(an / b);
        answer.den = FW'(ad / b);
        return answer;
    endfunction

    task automatic report_mismatch(input string field, input int got, input int want);
        $display("[%0t] mismatch on %s: got %0d, want %0d", $realtime, field, got, want);
        error_count++;
    endtask

    // Offer one target on s_axis and hold it until taken. Entered and left at a
    // falling edge; tvalid stays high on return so back-to-back words need no
    // second assignment in the same step.
    task automatic offer_target(input logic [FW-1:0] num, input logic [FW-1:0] den);
        int        gap;
        fraction_t target;
        gap = $urandom_range(0, sender_idle_max);
        target.num = num;
        target.den = den;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= TW'(target);
        @(posedge clk);
        while (!(s_axis_tvalid && s_axis_tready))
            @(posedge clk);
        expected_nearest.push_back(nearest_fraction(target));
        @(negedge clk);
    endtask

    task automatic wait_for_results();
        s_axis_tvalid <= 1'b0;
        while (expected_nearest.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Result side: check each word taken, then draw the stall before the next.
    // A hold requested by a test is counted down here, in this process alone.
    initial
    begin : result_checker
        fraction_t got;
        fraction_t want;
        int        stall_left;
        int        hold_left;
        stall_left = 0;
        hold_left  = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_axis_tvalid && m_axis_tready)
            begin
                got = fraction_t'(m_axis_tdata[2*FW-1:0]);
                if (expected_nearest.size() == 0)
                begin
                    // a word arrived with none pending
                    report_mismatch("pending result words", 1, 0);
                end
                else
                begin
                    want = expected_nearest.pop_front();
                    if (got.num !== want.num)
                        report_mismatch("near_numerator", got.num, want.num);
                    if (got.den !== want.den)
                        report_mismatch("near_denominator", got.den, want.den);
                end
                stall_left = $urandom_range(0, receiver_stall_max);
            end
            @(negedge clk);
            if (hold_request > 0)
            begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                m_axis_tready <= 1'b0;
                hold_left--;
            end
            else if (stall_left > 0)
            begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    // Mostly proper fractions strictly inside (0,1), where the full scan runs;
    // the rest are the short cases: zero, one, above one and zero denominator.
    function automatic fraction_t random_target();
        fraction_t target;
        int        pick;
        int        d;
        pick = $urandom_range(0, 9);
        if (pick <= 6)
        begin
            d = ($urandom_range(0, 2) == 0) ? $urandom_range(2, 1000) : $urandom_range(2, 32767);
            target.den = FW'(d);
            target.num = FW'($urandom_range(1, d - 1));
        end
        else if (pick == 7)
        begin
            d = $urandom_range(1, 32767);
            target.den = FW'(d);
            target.num = ($urandom_range(0, 1) == 0) ? '0 : FW'(d);
        end
        else if (pick == 8)
        begin
            d = $urandom_range(1, 32766);
            target.den = FW'(d);
            target.num = FW'($urandom_range(d + 1, 32767));
        end
        else
        begin
            target.den = '0;
            target.num = FW'($urandom_range(0, 32767));
        end
        return target;
    endfunction

    // Field extremes and every named corner: zero and one, numerator above
    // denominator, zero denominator, an exact midpoint tie, small targets
    // and targets close to the ends of the range.
    task automatic test_directed_corners();
        offer_target(15'd0, 15'd1);
        offer_target(15'd0, 15'd32767);
        offer_target(15'd1, 15'd1);
        offer_target(15'd32767, 15'd32767);
        offer_target(15'd1, 15'd32767);
        offer_target(15'd32766, 15'd32767);
        offer_target(15'd16383, 15'd32767);
        offer_target(15'd1, 15'd2);
        offer_target(15'd3, 15'd7);
        offer_target(15'd999, 15'd1000);
        offer_target(15'd1, 15'd1001);
        offer_target(15'd12345, 15'd32767);
        offer_target(15'd21845, 15'd32766);
        offer_target(15'd5, 15'd3);
        offer_target(15'd32767, 15'd1);
        offer_target(15'd32767, 15'd32766);
        offer_target(15'd0, 15'd0);
        offer_target(15'd1, 15'd0);
        offer_target(15'd32767, 15'd0);
        offer_target(15'd10922, 15'd21845);
        wait_for_results();
    endtask

    task automatic test_random_targets();
        fraction_t target;
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            target = random_target();
            offer_target(target.num, target.den);
        end
        wait_for_results();
    endtask

    // Drop all idling on both sides for a stretch of back-to-back words.
    task automatic test_back_to_back();
        fraction_t target;
        sender_idle_max    = 0;
        receiver_stall_max = 0;
        for (int i = 0; i < B2B_ITEMS; i++)
        begin
            target = random_target();
            offer_target(target.num, target.den);
        end
        wait_for_results();
        sender_idle_max    = IDLE_MAX;
        receiver_stall_max = IDLE_MAX;
    endtask

    // Hold the receiver off long enough for the output register and the scan
    // to fill, so that s_axis_tready drops while words are still offered.
    task automatic test_output_backpressure();
        fraction_t target;
        sender_idle_max = 0;
        hold_request    = FILL_HOLD;
        for (int i = 0; i < FILL_ITEMS; i++)
        begin
            target = random_target();
            offer_target(target.num, target.den);
        end
        wait_for_results();
        sender_idle_max = IDLE_MAX;
    endtask

    initial
    begin : stimulus
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_directed_corners();
        test_random_targets();
        test_back_to_back();
        test_output_backpressure();

        // let any stray word surface before the verdict
        repeat (SCAN_CYCLES + 40) @(posedge clk);
        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
